// ===== src/byte_offset_to_chs_mapper_unit_macros.svh =====
// Assertion helpers shared by the mapper's modules.
`ifndef BYTE_OFFSET_TO_CHS_MAPPER_UNIT_MACROS_SVH
`define BYTE_OFFSET_TO_CHS_MAPPER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BOCHS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BOCHS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bochs_pkg.sv =====
package bochs_pkg;

    // Field and register widths.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned TRK_W      = 8;
    localparam int unsigned SEC_W      = 8;
    localparam int unsigned SIZE_W     = 15;
    localparam int unsigned BYTE_W     = 14;
    localparam int unsigned MODE_W     = 2;

    // Internal widths: a count of sectors, tracks or heads, the sector index
    // inside one disk image, sectors per disk and bytes per disk.
    localparam int unsigned CNT_W   = 9;
    localparam int unsigned IDX_W   = 17;
    localparam int unsigned UNITS_W = 18;
    localparam int unsigned MOD_W   = 32;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 15'd16384;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_TRACK    = 3'd0,
        REG_LAST_TRACK     = 3'd1,
        REG_FIRST_HEAD     = 3'd2,
        REG_LAST_HEAD      = 3'd3,
        REG_SECTOR_BYTES   = 3'd4,
        REG_FIRST_SECTOR   = 3'd5,
        REG_LAST_SECTOR    = 3'd6,
        REG_INTERLACE_MODE = 3'd7
    } cfg_idx_t;

    // Interlace modes. The fourth code behaves as sector-only wrap.
    localparam logic [MODE_W-1:0] MODE_SEQUENCED   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INTERLEAVED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SECTOR_ONLY = 2'd2;

    // Geometry after reset.
    localparam logic [TRK_W-1:0]  RST_FIRST_TRACK  = 8'd0;
    localparam logic [TRK_W-1:0]  RST_LAST_TRACK   = 8'd79;
    localparam logic              RST_FIRST_HEAD   = 1'b0;
    localparam logic              RST_LAST_HEAD    = 1'b1;
    localparam logic [SIZE_W-1:0] RST_SECTOR_BYTES = 15'd256;
    localparam logic [SEC_W-1:0]  RST_FIRST_SECTOR = 8'd0;
    localparam logic [SEC_W-1:0]  RST_LAST_SECTOR  = 8'd9;
    localparam logic [MODE_W-1:0] RST_MODE         = MODE_SEQUENCED;

    // Derived geometry after reset: sectors per track, tracks (second digit
    // in sequenced mode), sectors per disk and bytes per disk.
    localparam logic [CNT_W-1:0] RST_NSEC =
        CNT_W'(RST_LAST_SECTOR - RST_FIRST_SECTOR + 1);
    localparam logic [CNT_W-1:0] RST_N2 =
        CNT_W'(RST_LAST_TRACK - RST_FIRST_TRACK + 1);
    localparam logic [UNITS_W-1:0] RST_UNITS =
        UNITS_W'(RST_NSEC * RST_N2 * (RST_LAST_HEAD - RST_FIRST_HEAD + 1));
    localparam logic [MOD_W-1:0] RST_DISK_MOD = MOD_W'(RST_UNITS * RST_SECTOR_BYTES);

    // Geometry as the datapath sees it.
    typedef struct packed {
        logic [TRK_W-1:0]  first_track;
        logic              first_head;
        logic [SEC_W-1:0]  first_sector;
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] size;      // sector size clamped to 1..16384
        logic [CNT_W-1:0]  nsec;      // sector IDs per track
        logic [CNT_W-1:0]  n2;        // radix of the second digit
        logic [MOD_W-1:0]  disk_mod;  // bytes before the offset wraps
    } geom_t;

endpackage

// ===== src/bochs_div.sv =====
`include "byte_offset_to_chs_mapper_unit_macros.svh"

module bochs_div #(
    parameter int unsigned VW  = 15,
    parameter int unsigned QW  = 17,
    parameter int unsigned SBW = 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv_i,
    input  logic           vld_i,
    input  logic [VW-1:0]  num_hi_i,
    input  logic [QW-1:0]  num_lo_i,
    input  logic [VW-1:0]  divisor_i,
    input  logic [SBW-1:0] sb_i,
    output logic           vld_o,
    output logic [QW-1:0]  quot_o,
    output logic [VW-1:0]  rem_o,
    output logic [SBW-1:0] sb_o
);
    // Restoring divider, one quotient bit per stage. The dividend is
    // {num_hi_i, num_lo_i} with num_hi_i below the divisor, so the quotient
    // fits in QW bits. The low dividend bits shift out of the top of qd_reg
    // while the quotient bits shift in at the bottom.

    logic [VW-1:0]  pr_reg  [QW];
    logic [QW-1:0]  qd_reg  [QW];
    logic [SBW-1:0] sb_reg  [QW];
    logic           vld_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [VW-1:0]  pr_in;
        logic [QW-1:0]  qd_in;
        logic [SBW-1:0] sb_in;
        logic           vld_in;
        logic [VW:0]    trial;
        logic [VW+1:0]  diff;
        logic           take;
        logic [VW-1:0]  pr_next;
        logic [QW-1:0]  qd_next;

        if (j == 0) begin : g_first
            assign pr_in  = num_hi_i;
            assign qd_in  = num_lo_i;
            assign sb_in  = sb_i;
            assign vld_in = vld_i;
        end else begin : g_later
            assign pr_in  = pr_reg[j-1];
            assign qd_in  = qd_reg[j-1];
            assign sb_in  = sb_reg[j-1];
            assign vld_in = vld_reg[j-1];
        end

        // Bring down the next dividend bit and try to subtract the divisor.
        assign trial   = {pr_in, qd_in[QW-1]};
        assign diff    = {1'b0, trial} - {2'b00, divisor_i};
        assign take    = ~diff[VW+1];
        assign pr_next = take ? diff[VW-1:0] : trial[VW-1:0];
        assign qd_next = {qd_in[QW-2:0], take};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (adv_i) begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv_i) begin
                pr_reg[j] <= pr_next;
                qd_reg[j] <= qd_next;
                sb_reg[j] <= sb_in;
            end
        end
    end

    assign vld_o  = vld_reg[QW-1];
    assign quot_o = qd_reg[QW-1];
    assign rem_o  = pr_reg[QW-1];
    assign sb_o   = sb_reg[QW-1];

    // A finished remainder is always reduced below the divisor.
    `BOCHS_ASSERT_NOW(a_rem_reduced, aclk, aresetn, vld_o, rem_o < divisor_i,
        "divider remainder not below divisor")
    // A stall freezes the last stage.
    `BOCHS_ASSERT_NEXT(a_stall_holds, aclk, aresetn, !adv_i && vld_o,
        vld_o && $stable(quot_o) && $stable(rem_o), "divider output moved during stall")

endmodule

// ===== src/bochs_cfg.sv =====
module bochs_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  bochs_pkg::cfg_idx_t                cfg_index,
    input  logic [bochs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output bochs_pkg::geom_t                   geom_o
);
    import bochs_pkg::*;

    logic [TRK_W-1:0]   first_track_reg;
    logic [TRK_W-1:0]   last_track_reg;
    logic               first_head_reg;
    logic               last_head_reg;
    logic [SIZE_W-1:0]  sector_bytes_reg;
    logic [SEC_W-1:0]   first_sector_reg;
    logic [SEC_W-1:0]   last_sector_reg;
    logic [MODE_W-1:0]  mode_reg;

    logic [SIZE_W-1:0]  size_reg;
    logic [SIZE_W-1:0]  size_next;
    logic [CNT_W-1:0]   nsec_reg;
    logic [CNT_W-1:0]   nsec_next;
    logic [CNT_W-1:0]   n2_reg;
    logic [CNT_W-1:0]   n2_next;
    logic [UNITS_W-1:0] units_reg;
    logic [UNITS_W-1:0] units_next;
    logic [MOD_W-1:0]   disk_mod_reg;
    logic [MOD_W-1:0]   disk_mod_next;

    logic [SEC_W-1:0]   sec_span;
    logic [TRK_W-1:0]   trk_span;
    logic [CNT_W-1:0]   ntrk;
    logic               geo_ok;
    logic               two_heads;
    logic [CNT_W:0]     trk_hd;
    logic [CNT_W+CNT_W:0]         units_full;
    logic [SIZE_W+UNITS_W-1:0]    mod_full;

    // Register file, written one register at a time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_track_reg  <= RST_FIRST_TRACK;
            last_track_reg   <= RST_LAST_TRACK;
            first_head_reg   <= RST_FIRST_HEAD;
            last_head_reg    <= RST_LAST_HEAD;
            sector_bytes_reg <= RST_SECTOR_BYTES;
            first_sector_reg <= RST_FIRST_SECTOR;
            last_sector_reg  <= RST_LAST_SECTOR;
            mode_reg         <= RST_MODE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FIRST_TRACK:    first_track_reg  <= cfg_wdata[TRK_W-1:0];
                REG_LAST_TRACK:     last_track_reg   <= cfg_wdata[TRK_W-1:0];
                REG_FIRST_HEAD:     first_head_reg   <= cfg_wdata[0];
                REG_LAST_HEAD:      last_head_reg    <= cfg_wdata[0];
                REG_SECTOR_BYTES:   sector_bytes_reg <= cfg_wdata[SIZE_W-1:0];
                REG_FIRST_SECTOR:   first_sector_reg <= cfg_wdata[SEC_W-1:0];
                REG_LAST_SECTOR:    last_sector_reg  <= cfg_wdata[SEC_W-1:0];
                REG_INTERLACE_MODE: mode_reg         <= cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // First derived stage: clamped sector size, digit radices and the
    // number of sectors in one pass over the disk. An inverted track or head
    // range, or sector-only wrap, keeps every item on the first track.
    always_comb begin
        sec_span = last_sector_reg - first_sector_reg;
        trk_span = last_track_reg - first_track_reg;
        ntrk     = CNT_W'(trk_span) + CNT_W'(1);

        if (sector_bytes_reg == '0) begin
            size_next = SIZE_W'(1);
        end else if (sector_bytes_reg > SIZE_MAX) begin
            size_next = SIZE_MAX;
        end else begin
            size_next = sector_bytes_reg;
        end

        if (last_sector_reg >= first_sector_reg) begin
            nsec_next = CNT_W'(sec_span) + CNT_W'(1);
        end else begin
            nsec_next = CNT_W'(1);
        end

        geo_ok    = (last_track_reg >= first_track_reg) && (last_head_reg >= first_head_reg);
        two_heads = last_head_reg != first_head_reg;

        if (geo_ok && (mode_reg == MODE_SEQUENCED || mode_reg == MODE_INTERLEAVED)) begin
            trk_hd = two_heads ? {ntrk, 1'b0} : {1'b0, ntrk};
        end else begin
            trk_hd = (CNT_W+1)'(1);
        end

        if (!geo_ok) begin
            n2_next = CNT_W'(1);
        end else if (mode_reg == MODE_INTERLEAVED) begin
            n2_next = two_heads ? CNT_W'(2) : CNT_W'(1);
        end else begin
            n2_next = ntrk;
        end

        // An inverted track or head range also pins the sector ID, so one
        // pass over the disk is a single sector.
        units_full = nsec_next * trk_hd;
        units_next = geo_ok ? units_full[UNITS_W-1:0] : UNITS_W'(1);
    end

    // Second derived stage: bytes per pass over the disk.
    always_comb begin
        mod_full      = size_reg * units_reg;
        disk_mod_next = mod_full[MOD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= RST_SECTOR_BYTES;
            nsec_reg     <= RST_NSEC;
            n2_reg       <= RST_N2;
            units_reg    <= RST_UNITS;
            disk_mod_reg <= RST_DISK_MOD;
        end else begin
            size_reg     <= size_next;
            nsec_reg     <= nsec_next;
            n2_reg       <= n2_next;
            units_reg    <= units_next;
            disk_mod_reg <= disk_mod_next;
        end
    end

    assign geom_o.first_track  = first_track_reg;
    assign geom_o.first_head   = first_head_reg;
    assign geom_o.first_sector = first_sector_reg;
    assign geom_o.mode         = mode_reg;
    assign geom_o.size         = size_reg;
    assign geom_o.nsec         = nsec_reg;
    assign geom_o.n2           = n2_reg;
    assign geom_o.disk_mod     = disk_mod_reg;

endmodule

// ===== src/byte_offset_to_chs_mapper_unit.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_byte_offset
// m_        out        m_valid / m_ready  m_track, m_head, m_sector, m_byte_in_sector
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// One item per cycle unless m_ready holds the pipeline; the four restoring
// dividers lie in series, each retiring one quotient bit per stage.
// Reset is synchronous and active low; it clears all valid bits and loads the
// reset geometry. There is no clearing pass.
// While a result waits on m_ready, the whole pipeline holds; an empty input
// stage still takes one more item.
// Derived geometry settles through the derived stages after a configuration write.
`include "byte_offset_to_chs_mapper_unit_macros.svh"

module byte_offset_to_chs_mapper_unit #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  bochs_pkg::cfg_idx_t               cfg_index,
    input  logic [bochs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [OFFSET_BITS-1:0]            s_byte_offset,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bochs_pkg::TRK_W-1:0]       m_track,
    output logic                              m_head,
    output logic [bochs_pkg::SEC_W-1:0]       m_sector,
    output logic [bochs_pkg::BYTE_W-1:0]      m_byte_in_sector
);
    import bochs_pkg::*;

    localparam int unsigned D_SBW = BYTE_W + SEC_W;

    geom_t geom;
    logic  adv;

    logic                   s0_vld_reg;
    logic [OFFSET_BITS-1:0] s0_offs_reg;
    logic                   s1_vld_reg;
    logic [OFFSET_BITS-1:0] s1_offs_reg;

    logic               a_vld;
    logic [MOD_W-1:0]   a_rem;
    logic               b_vld;
    logic [IDX_W-1:0]   b_quot;
    logic [SIZE_W-1:0]  b_rem;
    logic               c_vld;
    logic [CNT_W-1:0]   c_quot;
    logic [CNT_W-1:0]   c_rem;
    logic [BYTE_W-1:0]  c_sb;
    logic               d_vld;
    logic [SEC_W-1:0]   d_quot;
    logic [CNT_W-1:0]   d_rem;
    logic [D_SBW-1:0]   d_sb;

    logic [TRK_W-1:0]   trk_off;
    logic               hd_off;
    logic               m_valid_reg;
    logic [TRK_W-1:0]   m_track_reg;
    logic [TRK_W-1:0]   m_track_next;
    logic               m_head_reg;
    logic               m_head_next;
    logic [SEC_W-1:0]   m_sector_reg;
    logic [SEC_W-1:0]   m_sector_next;
    logic [BYTE_W-1:0]  m_byte_reg;
    logic [BYTE_W-1:0]  m_byte_next;

    bochs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .geom_o    (geom)
    );

    // The pipeline moves as one whenever the output register is free.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv || !s0_vld_reg;

    // Two input stages give the geometry products time to settle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                s0_vld_reg <= s_valid;
            end
            if (adv) begin
                s1_vld_reg <= s0_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            s0_offs_reg <= s_byte_offset;
        end
        if (adv) begin
            s1_offs_reg <= s0_offs_reg;
        end
    end

    // Wrap the offset into one pass over the disk.
    bochs_div #(.VW(MOD_W), .QW(OFFSET_BITS), .SBW(1)) u_div_wrap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv_i     (adv),
        .vld_i     (s1_vld_reg),
        .num_hi_i  ('0),
        .num_lo_i  (s1_offs_reg),
        .divisor_i (geom.disk_mod),
        .sb_i      (1'b0),
        .vld_o     (a_vld),
        .quot_o    (),
        .rem_o     (a_rem),
        .sb_o      ()
    );

    // Split the wrapped offset into sector index and byte in sector.
    bochs_div #(.VW(SIZE_W), .QW(IDX_W), .SBW(1)) u_div_size (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv_i     (adv),
        .vld_i     (a_vld),
        .num_hi_i  (a_rem[MOD_W-1:IDX_W]),
        .num_lo_i  (a_rem[IDX_W-1:0]),
        .divisor_i (geom.size),
        .sb_i      (1'b0),
        .vld_o     (b_vld),
        .quot_o    (b_quot),
        .rem_o     (b_rem),
        .sb_o      ()
    );

    // Peel off the sector ID digit.
    bochs_div #(.VW(CNT_W), .QW(CNT_W), .SBW(BYTE_W)) u_div_sec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv_i     (adv),
        .vld_i     (b_vld),
        .num_hi_i  (CNT_W'(b_quot[IDX_W-1:CNT_W])),
        .num_lo_i  (b_quot[CNT_W-1:0]),
        .divisor_i (geom.nsec),
        .sb_i      (b_rem[BYTE_W-1:0]),
        .vld_o     (c_vld),
        .quot_o    (c_quot),
        .rem_o     (c_rem),
        .sb_o      (c_sb)
    );

    // Split the rest into the second digit and the third.
    bochs_div #(.VW(CNT_W), .QW(SEC_W), .SBW(D_SBW)) u_div_th (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv_i     (adv),
        .vld_i     (c_vld),
        .num_hi_i  (CNT_W'(c_quot[CNT_W-1:SEC_W])),
        .num_lo_i  (c_quot[SEC_W-1:0]),
        .divisor_i (geom.n2),
        .sb_i      ({c_sb, c_rem[SEC_W-1:0]}),
        .vld_o     (d_vld),
        .quot_o    (d_quot),
        .rem_o     (d_rem),
        .sb_o      (d_sb)
    );

    // Sequenced mode: tracks are the second digit and heads the third.
    // Interleaved mode swaps them. Otherwise both digits are zero.
    always_comb begin
        if (geom.mode == MODE_INTERLEAVED) begin
            trk_off = d_quot;
            hd_off  = d_rem[0];
        end else begin
            trk_off = d_rem[TRK_W-1:0];
            hd_off  = d_quot[0];
        end
        m_track_next  = geom.first_track + trk_off;
        m_head_next   = geom.first_head ^ hd_off;
        m_sector_next = geom.first_sector + d_sb[SEC_W-1:0];
        m_byte_next   = d_sb[SEC_W +: BYTE_W];
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= d_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_track_reg  <= m_track_next;
            m_head_reg   <= m_head_next;
            m_sector_reg <= m_sector_next;
            m_byte_reg   <= m_byte_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_track          = m_track_reg;
    assign m_head           = m_head_reg;
    assign m_sector         = m_sector_reg;
    assign m_byte_in_sector = m_byte_reg;

    // A result's sector ID lies inside the configured sector range.
    `BOCHS_ASSERT_NOW(a_sector_in_range, aclk, aresetn, m_valid_reg,
        SEC_W'(m_sector_reg - geom.first_sector) < geom.nsec, "sector out of range")
    // The byte position is below the sector size.
    `BOCHS_ASSERT_NOW(a_byte_in_range, aclk, aresetn, m_valid_reg,
        ({1'b0, m_byte_reg} < geom.size), "byte position not below sector size")
    // Sector-only wrap never leaves the first track.
    `BOCHS_ASSERT_NOW(a_sector_only_track, aclk, aresetn,
        m_valid_reg && geom.mode == MODE_SECTOR_ONLY, m_track_reg == geom.first_track,
        "track moved in sector-only mode")

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bochs_pkg::*;

    localparam int OFF_W = 32;
    localparam int LATENCY = OFF_W + 37;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 5000;
    localparam int N_PHASES = 15;
    // The fourth interlace code has no name in the package; it wraps like sector-only mode.
    localparam logic [MODE_W-1:0] MODE_WRAP_ALIAS = 2'd3;

    typedef longint unsigned u64_t;

    // One mapped position: track, head, sector ID and byte within the sector.
    typedef struct packed {
        logic [TRK_W-1:0]  track;
        logic              head;
        logic [SEC_W-1:0]  sector;
        logic [BYTE_W-1:0] byte_in_sector;
    } chs_t;

    // Raw register words for one geometry, in the order of the register indexes.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] first_track;
        logic [CFG_DATA_W-1:0] last_track;
        logic [CFG_DATA_W-1:0] first_head;
        logic [CFG_DATA_W-1:0] last_head;
        logic [CFG_DATA_W-1:0] sector_bytes;
        logic [CFG_DATA_W-1:0] first_sector;
        logic [CFG_DATA_W-1:0] last_sector;
        logic [CFG_DATA_W-1:0] mode;
    } geometry_t;

    // Keeps its own copy of the disk geometry, maps each accepted offset to the
    // position it should land on, and checks the mapped positions in order.
    class chs_tracker;
        logic [TRK_W-1:0]  first_track;
        logic [TRK_W-1:0]  last_track;
        logic              first_head;
        logic              last_head;
        logic [SIZE_W-1:0] sector_bytes;
        logic [SEC_W-1:0]  first_sector;
        logic [SEC_W-1:0]  last_sector;
        logic [MODE_W-1:0] mode;
        chs_t              pending_chs[$];
        int unsigned       mismatches;

        function new();
            first_track  = RST_FIRST_TRACK;
            last_track   = RST_LAST_TRACK;
            first_head   = RST_FIRST_HEAD;
            last_head    = RST_LAST_HEAD;
            sector_bytes = RST_SECTOR_BYTES;
            first_sector = RST_FIRST_SECTOR;
            last_sector  = RST_LAST_SECTOR;
            mode         = RST_MODE;
            mismatches   = 0;
        endfunction

        // Each register keeps only its own low bits of the written word.
        function void write_reg(cfg_idx_t r, logic [CFG_DATA_W-1:0] d);
            case (r)
                REG_FIRST_TRACK:    first_track = d[TRK_W-1:0];
                REG_LAST_TRACK:     last_track = d[TRK_W-1:0];
                REG_FIRST_HEAD:     first_head = d[0];
                REG_LAST_HEAD:      last_head = d[0];
                REG_SECTOR_BYTES:   sector_bytes = d[SIZE_W-1:0];
                REG_FIRST_SECTOR:   first_sector = d[SEC_W-1:0];
                REG_LAST_SECTOR:    last_sector = d[SEC_W-1:0];
                REG_INTERLACE_MODE: mode = d[MODE_W-1:0];
                default: ;
            endcase
        endfunction

        // A zero size counts as one byte, and sizes above 16384 are clamped.
        function u64_t sector_size();
            if (sector_bytes == '0) begin
                return 1;
            end
            if (u64_t'(sector_bytes) > 16384) begin
                return 16384;
            end
            return u64_t'(sector_bytes);
        endfunction

        // An inverted sector range leaves one sector per track.
        function u64_t sectors_per_track();
            if (last_sector >= first_sector) begin
                return u64_t'(last_sector) - u64_t'(first_sector) + 1;
            end
            return 1;
        endfunction

        function bit ranges_ok();
            return (last_track >= first_track) && (last_head >= first_head);
        endfunction

        function u64_t disk_bytes();
            u64_t units;
            units = sectors_per_track();
            if (ranges_ok()) begin
                units = units * (u64_t'(last_track) - u64_t'(first_track) + 1)
                              * (u64_t'(last_head) - u64_t'(first_head) + 1);
            end
            return units * sector_size();
        endfunction

        function chs_t map_offset(logic [OFF_W-1:0] offs);
            chs_t r;
            u64_t size;
            u64_t idx;
            u64_t nsec;
            u64_t ntrk;
            u64_t nhd;
            size = sector_size();
            nsec = sectors_per_track();
            idx = u64_t'(offs) / size;
            r.track = first_track;
            r.head = first_head;
            r.sector = first_sector;
            r.byte_in_sector = BYTE_W'(u64_t'(offs) % size);
            // An inverted track or head range pins track, head and sector to the first position.
            if (ranges_ok()) begin
                ntrk = u64_t'(last_track) - u64_t'(first_track) + 1;
                nhd = u64_t'(last_head) - u64_t'(first_head) + 1;
                case (mode)
                    MODE_SEQUENCED: begin
                        idx = idx % (nsec * ntrk * nhd);
                        r.sector = first_sector + SEC_W'(idx % nsec);
                        r.track = first_track + TRK_W'((idx / nsec) % ntrk);
                        r.head = first_head + 1'(idx / (nsec * ntrk));
                    end
                    MODE_INTERLEAVED: begin
                        idx = idx % (nsec * ntrk * nhd);
                        r.sector = first_sector + SEC_W'(idx % nsec);
                        r.head = first_head + 1'((idx / nsec) % nhd);
                        r.track = first_track + TRK_W'(idx / (nsec * nhd));
                    end
                    default: begin
                        r.sector = first_sector + SEC_W'(idx % nsec);
                    end
                endcase
            end
            return r;
        endfunction

        function void note_offset(logic [OFF_W-1:0] offs);
            pending_chs.push_back(map_offset(offs));
        endfunction

        function void check_chs(logic [TRK_W-1:0] trk, logic hd, logic [SEC_W-1:0] sec,
                                 logic [BYTE_W-1:0] bis);
            chs_t want;
            if (pending_chs.size() == 0) begin
                $error("unexpected result: track %0d head %0d sector %0d byte_in_sector %0d",
                       trk, hd, sec, bis);
                mismatches++;
                return;
            end
            want = pending_chs.pop_front();
            if (trk !== want.track) begin
                $error("track: expected %0d, actual %0d", want.track, trk);
                mismatches++;
            end
            if (hd !== want.head) begin
                $error("head: expected %0d, actual %0d", want.head, hd);
                mismatches++;
            end
            if (sec !== want.sector) begin
                $error("sector: expected %0d, actual %0d", want.sector, sec);
                mismatches++;
            end
            if (bis !== want.byte_in_sector) begin
                $error("byte_in_sector: expected %0d, actual %0d", want.byte_in_sector, bis);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_chs.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [OFF_W-1:0]      s_byte_offset;
    logic                  m_valid;
    logic                  m_ready;
    logic [TRK_W-1:0]      m_track;
    logic                  m_head;
    logic [SEC_W-1:0]      m_sector;
    logic [BYTE_W-1:0]     m_byte_in_sector;

    chs_tracker  sb = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned quiet_cycles = 0;
    geometry_t   phase_geo[N_PHASES];

    byte_offset_to_chs_mapper_unit #(
        .OFFSET_BITS(OFF_W)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_byte_offset(s_byte_offset),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_track(m_track),
        .m_head(m_head),
        .m_sector(m_sector),
        .m_byte_in_sector(m_byte_in_sector)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls, or one long hold-off on request so the pipeline fills.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every mapped position is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_chs(m_track, m_head, m_sector, m_byte_in_sector);
        end
    end

    // The run ends if no item moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one offset after an optional random gap and waits for it to be taken.
    task automatic send_offset(input logic [OFF_W-1:0] offs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_offset <= offs;
        do @(posedge aclk); while (!s_ready);
        sb.note_offset(offs);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
    endtask

    task automatic write_cfg(input cfg_idx_t r, input logic [CFG_DATA_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= d;
        sb.write_reg(r, d);
        @(negedge aclk);
    endtask

    // Writes all eight registers, then gives the derived geometry time to settle.
    task automatic apply_geometry(input geometry_t g);
        write_cfg(REG_FIRST_TRACK, g.first_track);
        write_cfg(REG_LAST_TRACK, g.last_track);
        write_cfg(REG_FIRST_HEAD, g.first_head);
        write_cfg(REG_LAST_HEAD, g.last_head);
        write_cfg(REG_SECTOR_BYTES, g.sector_bytes);
        write_cfg(REG_FIRST_SECTOR, g.first_sector);
        write_cfg(REG_LAST_SECTOR, g.last_sector);
        write_cfg(REG_INTERLACE_MODE, g.mode);
        cfg_wr_en <= 1'b0;
        repeat (4) @(negedge aclk);
    endtask

    // Full-width random words; when ordered, the ranges are kept the right way round.
    function automatic geometry_t random_geometry(input bit ordered);
        geometry_t g;
        logic [CFG_DATA_W-1:0] t;
        g.first_track  = CFG_DATA_W'($urandom_range(32767));
        g.last_track   = CFG_DATA_W'($urandom_range(32767));
        g.first_head   = CFG_DATA_W'($urandom_range(32767));
        g.last_head    = CFG_DATA_W'($urandom_range(32767));
        g.sector_bytes = CFG_DATA_W'($urandom_range(32767));
        g.first_sector = CFG_DATA_W'($urandom_range(32767));
        g.last_sector  = CFG_DATA_W'($urandom_range(32767));
        g.mode         = CFG_DATA_W'($urandom_range(32767));
        if (ordered) begin
            if (g.last_track[TRK_W-1:0] < g.first_track[TRK_W-1:0]) begin
                t = g.last_track;
                g.last_track = g.first_track;
                g.first_track = t;
            end
            if (g.last_head[0] < g.first_head[0]) begin
                t = g.last_head;
                g.last_head = g.first_head;
                g.first_head = t;
            end
            if (g.last_sector[SEC_W-1:0] < g.first_sector[SEC_W-1:0]) begin
                t = g.last_sector;
                g.last_sector = g.first_sector;
                g.first_sector = t;
            end
        end
        return g;
    endfunction

    // Mix of whole-range offsets, offsets inside the disk, and offsets on or next to
    // sector and disk boundaries.
    function automatic logic [OFF_W-1:0] next_offset();
        u64_t disk;
        u64_t step;
        u64_t k;
        int unsigned pick;
        disk = sb.disk_bytes();
        step = sb.sector_size();
        pick = $urandom_range(99);
        if (pick < 30) begin
            return OFF_W'($urandom);
        end else if (pick < 70) begin
            return OFF_W'(u64_t'($urandom) % disk);
        end else if (pick < 90) begin
            k = u64_t'($urandom) % (disk / step + 1);
            return OFF_W'(k * step + u64_t'($urandom_range(2)) - 1);
        end
        return OFF_W'(disk * u64_t'($urandom_range(3, 1)) + u64_t'($urandom_range(2)) - 1);
    endfunction

    initial begin
        logic [OFF_W-1:0] reset_geo_offsets[$];
        int n_items;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_FIRST_TRACK;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_byte_offset = '0;

        // Fixed geometries: common formats, each interlace code, clamped sector sizes,
        // inverted ranges and the extremes of every register.
        phase_geo[0]  = '{15'd0, 15'd79, 15'd0, 15'd1, 15'd512, 15'd1, 15'd9,
                          CFG_DATA_W'(MODE_SEQUENCED)};
        phase_geo[1]  = '{15'd0, 15'd79, 15'd0, 15'd1, 15'd512, 15'd1, 15'd18,
                          CFG_DATA_W'(MODE_INTERLEAVED)};
        phase_geo[2]  = '{15'd0, 15'd39, 15'd0, 15'd0, 15'd256, 15'd0, 15'd15,
                          CFG_DATA_W'(MODE_SECTOR_ONLY)};
        phase_geo[3]  = '{15'd10, 15'd20, 15'd1, 15'd1, 15'd1024, 15'd5, 15'd8,
                          CFG_DATA_W'(MODE_WRAP_ALIAS)};
        phase_geo[4]  = '{15'd0, 15'd3, 15'd0, 15'd1, 15'd0, 15'd0, 15'd3,
                          CFG_DATA_W'(MODE_SEQUENCED)};
        phase_geo[5]  = '{15'd0, 15'd255, 15'd0, 15'd1, 15'd32767, 15'd0, 15'd255,
                          CFG_DATA_W'(MODE_INTERLEAVED)};
        phase_geo[6]  = '{15'd0, 15'd255, 15'd0, 15'd1, 15'd16384, 15'd0, 15'd255,
                          CFG_DATA_W'(MODE_SEQUENCED)};
        phase_geo[7]  = '{15'd5, 15'd9, 15'd0, 15'd1, 15'd128, 15'd200, 15'd100,
                          CFG_DATA_W'(MODE_SEQUENCED)};
        phase_geo[8]  = '{15'd50, 15'd10, 15'd0, 15'd1, 15'd300, 15'd3, 15'd7,
                          CFG_DATA_W'(MODE_INTERLEAVED)};
        phase_geo[9]  = '{15'd0, 15'd9, 15'd1, 15'd0, 15'd7, 15'd0, 15'd4,
                          CFG_DATA_W'(MODE_SEQUENCED)};
        phase_geo[10] = '{15'd255, 15'd255, 15'd1, 15'd1, 15'd1, 15'd255, 15'd255,
                          CFG_DATA_W'(MODE_INTERLEAVED)};
        phase_geo[11] = '{15'd254, 15'd255, 15'd0, 15'd1, 15'd16383, 15'd250, 15'd255,
                          CFG_DATA_W'(MODE_SECTOR_ONLY)};
        phase_geo[12] = random_geometry(1'b1);
        phase_geo[13] = random_geometry(1'b1);
        phase_geo[14] = random_geometry(1'b0);

        // Offsets for the reset geometry: sector, track, head and disk edges,
        // plus the extremes and alternating bit patterns of the offset field.
        reset_geo_offsets = '{32'd0, 32'd1, 32'd255, 32'd256, 32'd2559, 32'd2560,
                              32'd204799, 32'd204800, 32'd409599, 32'd409600,
                              32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                              32'hAAAA_AAAA, 32'hFFFF_FFFF};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (reset_geo_offsets[i]) begin
            send_offset(reset_geo_offsets[i]);
        end
        wait_drained();

        // Each phase loads a geometry and streams offsets under one idling pattern.
        for (int p = 0; p < N_PHASES; p++) begin
            apply_geometry(phase_geo[p]);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 58;
                end
                default: begin
                    send_idle_pct = 31;
                    recv_stall_pct = 31;
                end
            endcase
            // The first phase is long and starts with the result side held off,
            // so the pipeline fills and pushes back on the offsets.
            n_items = 48;
            if (p == 0) begin
                n_items = 150;
                hold_req = 1'b1;
            end
            for (int i = 0; i < n_items; i++) begin
                send_offset(next_offset());
            end
            wait_drained();
        end

        repeat (LATENCY + 16) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
